[design/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg: shared types, constants and BCD helpers
// Register map layout, command codes and the BCD encode/decode functions used
// by the calendar register file.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // total byte map; the 6-bit address reaches at most 64 bytes
  localparam int REGISTER_BYTES = 64;
  localparam int ADDR_W         = 6;
  localparam int MAP_BYTES      = (REGISTER_BYTES > (1 << ADDR_W)) ? (1 << ADDR_W)
                                                                   : REGISTER_BYTES;
  localparam int TIME_BYTES     = 8;
  localparam int TIME_AW        = $clog2(TIME_BYTES);
  localparam int RAM_DEPTH      = (MAP_BYTES > TIME_BYTES) ? (MAP_BYTES - TIME_BYTES) : 1;
  localparam int RAM_AW         = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // time register byte positions
  localparam logic [TIME_AW-1:0] ADDR_SEC   = TIME_AW'(0);
  localparam logic [TIME_AW-1:0] ADDR_MIN   = TIME_AW'(1);
  localparam logic [TIME_AW-1:0] ADDR_HOUR  = TIME_AW'(2);
  localparam logic [TIME_AW-1:0] ADDR_DOW   = TIME_AW'(3);
  localparam logic [TIME_AW-1:0] ADDR_DATE  = TIME_AW'(4);
  localparam logic [TIME_AW-1:0] ADDR_MONTH = TIME_AW'(5);
  localparam logic [TIME_AW-1:0] ADDR_YEAR  = TIME_AW'(6);

  typedef logic [TIME_BYTES-1:0][7:0] time_regs_t;

  // control, year, month, date, dow, hours, minutes, seconds (halted)
  localparam time_regs_t TIME_RESET = {8'h00, 8'h00, 8'h01, 8'h01,
                                       8'h01, 8'h00, 8'h00, 8'h80};

  localparam logic [7:0] HALT_BIT  = 8'h80;
  localparam logic [7:0] MODE_12H  = 8'h40;
  localparam logic [7:0] PM_BIT    = 8'h20;

  // tens*10 + units, no BCD check (max 165)
  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    return 8'({1'b0, v[7:4], 3'b000}) + 8'({3'b000, v[7:4], 1'b0}) + 8'({4'h0, v[3:0]});
  endfunction

  // value below 200 to two BCD digits, modulo 100; /10 via *205 >> 11
  function automatic logic [7:0] bcd_enc(input logic [7:0] v);
    logic [6:0]  w;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    w = (v >= 8'd100) ? 7'(v - 8'd100) : v[6:0];
    p = 15'(w) * 15'd205;
    t = p[14:11];
    u = w - (7'(t) * 7'd10);
    return {t, u[3:0]};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[design/rtc_if.sv]
// ----------------------------------------------------------------------------
// rtc_if: request and result channels
// Valid/ready channels carrying one request and one result of the register file.
// ----------------------------------------------------------------------------
interface rtc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [rtc_pkg::ADDR_W-1:0] reg_addr;
  logic [7:0]                 write_data;

  modport source (output valid, command, reg_addr, write_data, input ready);
  modport sink   (input valid, command, reg_addr, write_data, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       clock_halted;

  modport source (output valid, read_data, clock_halted, input ready);
  modport sink   (input valid, read_data, clock_halted, output ready);
endinterface

[design/rtc_ram.sv]
// ----------------------------------------------------------------------------
// rtc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module rtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 56
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/bcd_rtc_calendar_registers.sv]
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_registers: BCD real-time clock / calendar register file
// 64-byte map: BCD time and date in bytes 0-6, control in 7, user RAM above.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_req  | in  | valid / ready | command, reg_addr, write_data
//  out_rsp | out | valid / ready | read_data, clock_halted
//
//  One request per cycle sustained while out_rsp.ready stays high; the result
//  is registered in the request register, then in the result register.
//  User RAM access is issued at accept; its read port sets the first stage.
//  Synchronous reset loads the time defaults (clock halted) and clears RAM
//  valid bits, so unwritten RAM reads as zero.
//  A stalled result holds the request stage; in_req.ready drops only when
//  both stages are full and out_rsp.ready is low.
// ----------------------------------------------------------------------------
module bcd_rtc_calendar_registers (
  input  logic             clk,
  input  logic             rst_n,
  rtc_in_if.sink           in_req,
  rtc_out_if.source        out_rsp
);

  // request stage
  logic                               s1_valid_r;
  rtc_pkg::cmd_t                      s1_cmd_r;
  logic [rtc_pkg::ADDR_W-1:0]         s1_addr_r;
  logic [7:0]                         s1_data_r;
  logic                               s1_ram_vld_r;
  logic                               s1_adv;

  // result stage
  logic                               out_valid_r;
  logic [7:0]                         out_rd_r;
  logic                               out_halt_r;

  rtc_pkg::time_regs_t                tr_r;
  rtc_pkg::time_regs_t                tr_nxt;
  rtc_pkg::time_regs_t                tick_regs;
  logic [rtc_pkg::RAM_DEPTH-1:0]      ram_vld_r;

  logic                               in_acc;
  logic                               in_is_ram;
  logic [rtc_pkg::RAM_AW-1:0]         ram_idx;
  logic                               ram_we;
  logic [7:0]                         ram_rdata;
  logic                               s1_is_time;
  logic                               s1_is_ram;
  logic [7:0]                         rd_nxt;

  // tick datapath
  logic [7:0] sec_i, min_i;
  logic       sec_wrap, min_wrap;
  logic [7:0] hr, hr_nxt;
  logic [4:0] h12;
  logic [5:0] h24_i;
  logic [7:0] h12_i;
  logic       pm_n, day_carry;
  logic [7:0] dom_i, mon, mon_i, yr;
  logic       leap;
  logic [4:0] limit;
  logic [7:0] dow_n, date_n, mon_n, yr_n;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_acc       = in_req.valid && in_req.ready;

  assign in_is_ram = (in_req.reg_addr >= rtc_pkg::ADDR_W'(rtc_pkg::TIME_BYTES)) &&
                     ({1'b0, in_req.reg_addr} < (rtc_pkg::ADDR_W + 1)'(rtc_pkg::MAP_BYTES));
  assign ram_idx   = rtc_pkg::RAM_AW'(in_req.reg_addr -
                                      rtc_pkg::ADDR_W'(rtc_pkg::TIME_BYTES));
  assign ram_we    = in_acc && in_is_ram &&
                     (rtc_pkg::cmd_t'(in_req.command) == rtc_pkg::CMD_WRITE);

  rtc_ram #(
    .WIDTH (8),
    .DEPTH (rtc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_idx),
    .wdata (in_req.write_data),
    .re    (in_acc),
    .raddr (ram_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_vld_r <= '0;
    end else if (ram_we) begin
      ram_vld_r[ram_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r     <= rtc_pkg::cmd_t'(in_req.command);
      s1_addr_r    <= in_req.reg_addr;
      s1_data_r    <= in_req.write_data;
      s1_ram_vld_r <= in_is_ram && ram_vld_r[ram_idx];
    end
  end

  // one-second advance with full carry, unless the halt bit is set
  always_comb begin
    tick_regs = tr_r;

    sec_i    = rtc_pkg::bcd_dec(tr_r[rtc_pkg::ADDR_SEC]) + 8'd1;
    sec_wrap = sec_i >= 8'd60;
    min_i    = rtc_pkg::bcd_dec(tr_r[rtc_pkg::ADDR_MIN]) + 8'd1;
    min_wrap = min_i >= 8'd60;

    hr    = tr_r[rtc_pkg::ADDR_HOUR];
    h12   = hr[4] ? (5'd10 + 5'({1'b0, hr[3:0]})) : 5'({1'b0, hr[3:0]});
    h24_i = 6'(rtc_pkg::bcd_dec({2'b00, hr[5:0]})) + 6'd1;
    pm_n  = hr[5];
    day_carry = 1'b0;
    if ((hr & rtc_pkg::MODE_12H) != 8'h00) begin
      if (h12 == 5'd11) begin
        h12_i     = 8'd12;
        day_carry = hr[5];
        pm_n      = !hr[5];
      end else if (h12 >= 5'd12) begin
        h12_i = 8'd1;
      end else begin
        h12_i = 8'(h12) + 8'd1;
      end
      hr_nxt = rtc_pkg::bcd_enc(h12_i) | rtc_pkg::MODE_12H |
               (pm_n ? rtc_pkg::PM_BIT : 8'h00);
    end else begin
      h12_i = 8'd0;
      if (h24_i < 6'd24) begin
        hr_nxt = rtc_pkg::bcd_enc(8'(h24_i));
      end else begin
        hr_nxt    = 8'h00;
        day_carry = 1'b1;
      end
    end

    dow_n = ((tr_r[rtc_pkg::ADDR_DOW] >= 8'd1) && (tr_r[rtc_pkg::ADDR_DOW] <= 8'd6)) ?
            tr_r[rtc_pkg::ADDR_DOW] + 8'd1 : 8'd1;
    dom_i = rtc_pkg::bcd_dec(tr_r[rtc_pkg::ADDR_DATE]) + 8'd1;
    mon   = rtc_pkg::bcd_dec(tr_r[rtc_pkg::ADDR_MONTH]);
    mon_i = mon + 8'd1;
    yr    = rtc_pkg::bcd_dec(tr_r[rtc_pkg::ADDR_YEAR]);
    // years 2000..2165: divisible by four, except 2100
    leap  = (yr[1:0] == 2'b00) && (yr != 8'd100);
    limit = ((mon >= 8'd1) && (mon <= 8'd12)) ? rtc_pkg::month_len(mon[3:0], leap) : 5'd31;

    date_n = rtc_pkg::bcd_enc(dom_i);
    mon_n  = tr_r[rtc_pkg::ADDR_MONTH];
    yr_n   = tr_r[rtc_pkg::ADDR_YEAR];
    if (dom_i > 8'(limit)) begin
      date_n = 8'h01;
      if (mon_i <= 8'd12) begin
        mon_n = rtc_pkg::bcd_enc(mon_i);
      end else begin
        mon_n = 8'h01;
        yr_n  = rtc_pkg::bcd_enc(yr + 8'd1);
      end
    end

    if ((tr_r[rtc_pkg::ADDR_SEC] & rtc_pkg::HALT_BIT) == 8'h00) begin
      tick_regs[rtc_pkg::ADDR_SEC] = sec_wrap ? 8'h00 : rtc_pkg::bcd_enc(sec_i);
      if (sec_wrap) begin
        tick_regs[rtc_pkg::ADDR_MIN] = min_wrap ? 8'h00 : rtc_pkg::bcd_enc(min_i);
        if (min_wrap) begin
          tick_regs[rtc_pkg::ADDR_HOUR] = hr_nxt;
          if (day_carry) begin
            tick_regs[rtc_pkg::ADDR_DOW]   = dow_n;
            tick_regs[rtc_pkg::ADDR_DATE]  = date_n;
            tick_regs[rtc_pkg::ADDR_MONTH] = mon_n;
            tick_regs[rtc_pkg::ADDR_YEAR]  = yr_n;
          end
        end
      end
    end
  end

  assign s1_is_time = s1_addr_r < rtc_pkg::ADDR_W'(rtc_pkg::TIME_BYTES);
  assign s1_is_ram  = !s1_is_time &&
                      ({1'b0, s1_addr_r} < (rtc_pkg::ADDR_W + 1)'(rtc_pkg::MAP_BYTES));

  // execute the request in stage 1
  always_comb begin
    tr_nxt = tr_r;
    rd_nxt = 8'h00;
    case (s1_cmd_r)
      rtc_pkg::CMD_TICK: begin
        tr_nxt = tick_regs;
        rd_nxt = tick_regs[rtc_pkg::ADDR_SEC];
      end
      rtc_pkg::CMD_WRITE: begin
        if (s1_is_time) begin
          tr_nxt[s1_addr_r[rtc_pkg::TIME_AW-1:0]] = s1_data_r;
          rd_nxt = s1_data_r;
        end else if (s1_is_ram) begin
          rd_nxt = s1_data_r;
        end
      end
      default: begin
        if (s1_is_time) begin
          rd_nxt = tr_r[s1_addr_r[rtc_pkg::TIME_AW-1:0]];
        end else if (s1_is_ram && s1_ram_vld_r) begin
          rd_nxt = ram_rdata;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_r <= rtc_pkg::TIME_RESET;
    end else if (s1_adv) begin
      tr_r <= tr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_rsp.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rd_r   <= rd_nxt;
      out_halt_r <= tr_nxt[rtc_pkg::ADDR_SEC][7];
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.read_data    = out_rd_r;
  assign out_rsp.clock_halted = out_halt_r;

endmodule

[design/rtc_checker.sv]
// ----------------------------------------------------------------------------
// rtc_checker: port-level checks for the calendar register file
// Watches request and result handshakes; bound to the top level.
// ----------------------------------------------------------------------------
module rtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_clock_halted
);

  // a result only shows up after some request was taken and passed the request and result registers
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request");

  // empty result register never blocks a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
                                $stable(out_clock_halted))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bcd_rtc_calendar_registers rtc_checker u_rtc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_read_data    (out_rsp.read_data),
  .out_clock_halted (out_rsp.clock_halted)
);

[verif/rtc_calendar_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtc_calendar_scoreboard_pkg: result prediction for the RTC register file
// Keeps its own copy of the time registers and user RAM. It predicts the
// read byte and the halt flag for each accepted request, and it checks the
// results in order.
// ----------------------------------------------------------------------------
package rtc_calendar_scoreboard_pkg;
  import rtc_pkg::*;

  // unused command encoding, decoded by the block as a read
  localparam logic [1:0]        CMD_SPARE    = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_CONTROL = ADDR_W'(7);

  typedef struct packed {
    logic [7:0] read_data;
    logic       clock_halted;
  } readback_t;

  class calendar_scoreboard;
    logic [7:0]  clock_bytes [TIME_BYTES];
    logic [7:0]  ram_bytes [1 << ADDR_W];
    readback_t   pending_reads [$];
    int unsigned failures;

    function new();
      clock_bytes = '{8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00};
      foreach (ram_bytes[i]) ram_bytes[i] = 8'h00;
      failures = 0;
    endfunction

    static function int unsigned from_bcd(logic [7:0] v);
      return v[7:4] * 10 + v[3:0];
    endfunction

    static function logic [7:0] to_bcd(int unsigned v);
      int unsigned r;
      r = v % 100;
      return {4'(r / 10), 4'(r % 10)};
    endfunction

    // out-of-range months count as 31 days
    static function int unsigned month_length(int unsigned month, int unsigned year);
      case (month)
        2: begin
          if ((year % 400) == 0 || ((year % 4) == 0 && (year % 100) != 0)) return 29;
          return 28;
        end
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    function void roll_date();
      int unsigned dow;
      int unsigned dom;
      int unsigned month;
      int unsigned year;
      dow = clock_bytes[ADDR_DOW];
      clock_bytes[ADDR_DOW] = (dow >= 1 && dow <= 6) ? 8'(dow + 1) : 8'h01;
      dom   = from_bcd(clock_bytes[ADDR_DATE]) + 1;
      month = from_bcd(clock_bytes[ADDR_MONTH]);
      year  = from_bcd(clock_bytes[ADDR_YEAR]) + 2000;
      if (dom <= month_length(month, year)) begin
        clock_bytes[ADDR_DATE] = to_bcd(dom);
        return;
      end
      clock_bytes[ADDR_DATE] = 8'h01;
      month++;
      if (month <= 12) begin
        clock_bytes[ADDR_MONTH] = to_bcd(month);
        return;
      end
      clock_bytes[ADDR_MONTH] = 8'h01;
      clock_bytes[ADDR_YEAR]  = to_bcd(year + 1);
    endfunction

    function void advance_one_second();
      int unsigned next_val;
      logic [7:0]  hr;
      logic        pm;
      logic        new_day;
      if ((clock_bytes[ADDR_SEC] & HALT_BIT) != 0) return;
      next_val = from_bcd(clock_bytes[ADDR_SEC]) + 1;
      if (next_val < 60) begin
        clock_bytes[ADDR_SEC] = to_bcd(next_val);
        return;
      end
      clock_bytes[ADDR_SEC] = 8'h00;
      next_val = from_bcd(clock_bytes[ADDR_MIN]) + 1;
      if (next_val < 60) begin
        clock_bytes[ADDR_MIN] = to_bcd(next_val);
        return;
      end
      clock_bytes[ADDR_MIN] = 8'h00;
      hr = clock_bytes[ADDR_HOUR];
      if ((hr & MODE_12H) != 0) begin
        // 12h: only bit 4 is tens; 11 -> 12 flips PM, 11PM -> 12AM is a new day
        pm       = (hr & PM_BIT) != 0;
        new_day  = 1'b0;
        next_val = hr[4] * 10 + hr[3:0];
        if (next_val == 11) begin
          next_val = 12;
          new_day  = pm;
          pm       = !pm;
        end else if (next_val >= 12) begin
          next_val = 1;
        end else begin
          next_val++;
        end
        clock_bytes[ADDR_HOUR] = to_bcd(next_val) | MODE_12H | (pm ? PM_BIT : 8'h00);
        if (!new_day) return;
      end else begin
        next_val = hr[5:4] * 10 + hr[3:0] + 1;
        if (next_val < 24) begin
          clock_bytes[ADDR_HOUR] = to_bcd(next_val);
          return;
        end
        clock_bytes[ADDR_HOUR] = 8'h00;
      end
      roll_date();
    endfunction

    function void note_request(logic [1:0] command, logic [ADDR_W-1:0] addr,
                               logic [7:0] data);
      readback_t res;
      case (command)
        CMD_TICK: advance_one_second();
        CMD_WRITE: begin
          if (addr < TIME_BYTES) clock_bytes[addr[TIME_AW-1:0]] = data;
          else if (addr < MAP_BYTES) ram_bytes[addr] = data;
        end
        default: ;
      endcase
      if (command == CMD_TICK) res.read_data = clock_bytes[ADDR_SEC];
      else if (addr < TIME_BYTES) res.read_data = clock_bytes[addr[TIME_AW-1:0]];
      else if (addr < MAP_BYTES) res.read_data = ram_bytes[addr];
      else res.read_data = 8'h00;
      res.clock_halted = clock_bytes[ADDR_SEC][7];
      pending_reads.push_back(res);
    endfunction

    function void check_result(logic [7:0] read_data, logic clock_halted);
      readback_t want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result read_data %02h clock_halted %0b",
                 $time, read_data, clock_halted);
        failures++;
        return;
      end
      want = pending_reads.pop_front();
      if (read_data !== want.read_data) begin
        $display("%0t: read_data mismatch: expected %02h, actual %02h",
                 $time, want.read_data, read_data);
        failures++;
      end
      if (clock_halted !== want.clock_halted) begin
        $display("%0t: clock_halted mismatch: expected %0b, actual %0b",
                 $time, want.clock_halted, clock_halted);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_reads.size();
    endfunction
  endclass

endpackage

[verif/tb_bcd_rtc_calendar_registers.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bcd_rtc_calendar_registers: testbench for the BCD RTC register file
// It runs directed rollover, 12h, leap-year and RAM cases, and then
// randomized calendar sequences with random gaps on the request side and
// stalls on the result side. Every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_bcd_rtc_calendar_registers;
  import rtc_pkg::*;
  import rtc_calendar_scoreboard_pkg::*;

  localparam int REQUESTS_PER_PHASE = 330;
  localparam int HOLD_OFF_CYCLES    = 64;
  localparam int DRAIN_CYCLES       = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int requests_sent     = 0;
  bit hold_off_request  = 1'b0;

  calendar_scoreboard board = new();

  rtc_in_if  in_req();
  rtc_out_if out_rsp();

  bcd_rtc_calendar_registers i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(1_000_000);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      board.check_result(out_rsp.read_data, out_rsp.clock_halted);
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_rsp.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.command    <= cmd;
    in_req.reg_addr   <= addr;
    in_req.write_data <= data;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    board.note_request(cmd, addr, data);
    requests_sent++;
  endtask

  task automatic write_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
    send_request(CMD_WRITE, addr, data);
  endtask

  // address and data are don't-care on a tick
  task automatic tick_clock();
    send_request(CMD_TICK, ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic set_clock(input logic [7:0] sec, input logic [7:0] min,
                           input logic [7:0] hour, input logic [7:0] dow,
                           input logic [7:0] date, input logic [7:0] month,
                           input logic [7:0] year);
    write_byte(ADDR_W'(ADDR_SEC), sec);
    write_byte(ADDR_W'(ADDR_MIN), min);
    write_byte(ADDR_W'(ADDR_HOUR), hour);
    write_byte(ADDR_W'(ADDR_DOW), dow);
    write_byte(ADDR_W'(ADDR_DATE), date);
    write_byte(ADDR_W'(ADDR_MONTH), month);
    write_byte(ADDR_W'(ADDR_YEAR), year);
  endtask

  task automatic wait_for_results();
    in_req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_bcd(input int unsigned lo, input int unsigned hi);
    return calendar_scoreboard::to_bcd($urandom_range(hi, lo));
  endfunction

  initial begin
    int          phase_end;
    bit          held;
    int unsigned month;
    int unsigned year;
    int unsigned mlen;
    int unsigned hr;
    logic [7:0]  hour_byte;
    logic [ADDR_W-1:0] addr;

    in_req.valid      = 1'b0;
    in_req.command    = CMD_READ;
    in_req.reg_addr   = '0;
    in_req.write_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset value, then a tick while halted
    send_request(CMD_READ, ADDR_W'(ADDR_SEC), 8'($urandom));
    tick_clock();
    // end of year 2099 rolls to 2000-01-01, weekday 7 wraps to 1
    set_clock(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99);
    tick_clock();
    send_request(CMD_READ, ADDR_W'(ADDR_DATE), 8'($urandom));
    send_request(CMD_READ, ADDR_W'(ADDR_YEAR), 8'($urandom));
    // 11:59:59 PM on Feb 28 of a leap year -> 12 AM Feb 29
    write_byte(ADDR_W'(ADDR_SEC), 8'h59);
    write_byte(ADDR_W'(ADDR_MIN), 8'h59);
    write_byte(ADDR_W'(ADDR_HOUR), MODE_12H | PM_BIT | 8'h11);
    write_byte(ADDR_W'(ADDR_DATE), 8'h28);
    write_byte(ADDR_W'(ADDR_MONTH), 8'h02);
    tick_clock();
    send_request(CMD_SPARE, ADDR_W'(ADDR_HOUR), 8'($urandom));
    send_request(CMD_READ, ADDR_W'(ADDR_DATE), 8'($urandom));
    // non-BCD seconds carry
    write_byte(ADDR_W'(ADDR_SEC), 8'h5F);
    tick_clock();
    write_byte(ADDR_W'(MAP_BYTES - 1), 8'hFF);
    send_request(CMD_READ, ADDR_W'(MAP_BYTES - 1), 8'h00);
    write_byte(ADDR_CONTROL, 8'h93);
    send_request(CMD_READ, ADDR_W'(TIME_BYTES), 8'hFF);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 0) begin
        sender_idle_pct   = 7;
        receiver_idle_pct = 47;
      end else if (phase == 1) begin
        sender_idle_pct   = 47;
        receiver_idle_pct = 7;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      held      = 1'b0;
      phase_end = requests_sent + REQUESTS_PER_PHASE;
      while (requests_sent < phase_end) begin
        if (!held && requests_sent >= phase_end - REQUESTS_PER_PHASE / 2) begin
          hold_off_request = 1'b1;
          held             = 1'b1;
        end
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            // just before a boundary: minute, hour, day, month or year end
            month = $urandom_range(12, 1);
            year  = $urandom_range(99, 0);
            mlen  = calendar_scoreboard::month_length(month, 2000 + year);
            if ($urandom_range(1)) begin
              hr        = ($urandom_range(3) == 0) ? $urandom_range(23, 0) : 23;
              hour_byte = calendar_scoreboard::to_bcd(hr);
            end else begin
              hr        = ($urandom_range(2) == 0) ? $urandom_range(12, 1)
                                                   : $urandom_range(12, 11);
              hour_byte = calendar_scoreboard::to_bcd(hr) | MODE_12H |
                          ($urandom_range(1) ? PM_BIT : 8'h00);
            end
            set_clock(random_bcd(56, 59),
                      ($urandom_range(3) != 0) ? 8'h59 : random_bcd(0, 59),
                      hour_byte, 8'($urandom_range(7, 0)),
                      random_bcd(mlen - 1, mlen),
                      calendar_scoreboard::to_bcd(month),
                      calendar_scoreboard::to_bcd(year));
            repeat ($urandom_range(6, 1)) tick_clock();
            repeat ($urandom_range(3, 1))
              send_request($urandom_range(1) ? CMD_READ : CMD_SPARE,
                           ADDR_W'($urandom_range(TIME_BYTES - 1)), 8'($urandom));
          end
          6: begin
            // any byte into a time register, halt bit included
            write_byte(ADDR_W'($urandom_range(TIME_BYTES - 1)), 8'($urandom));
            tick_clock();
          end
          7: begin
            addr = ADDR_W'($urandom_range(MAP_BYTES - 1, TIME_BYTES));
            write_byte(addr, 8'($urandom));
            send_request($urandom_range(1) ? CMD_READ : CMD_SPARE, addr, 8'($urandom));
          end
          8: send_request(2'($urandom), ADDR_W'($urandom), 8'($urandom));
          default: begin
            // garbage fields with the clock running
            set_clock({1'b0, 7'($urandom)}, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
            repeat ($urandom_range(8, 1)) tick_clock();
          end
        endcase
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
